// ===== hdl/sfhh_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sfhh_pkg: shared types and constants for the frame header hunter
// Sizes, register map codes, the configuration bundle and the job record that
// passes from the front end to the back end.
// ----------------------------------------------------------------------------
package sfhh_pkg;

	localparam int HDR_MAX   = 8;
	localparam int FRM_MAX   = 256;
	localparam int HDR_CNT_W = $clog2(HDR_MAX + 1);
	localparam int WIN_IDX_W = $clog2(HDR_MAX);
	localparam int FRM_W     = $clog2(FRM_MAX + 1);
	localparam int PAT_W     = 8 * HDR_MAX;

	localparam int Q_DEPTH   = 4;
	localparam int Q_PTR_W   = $clog2(Q_DEPTH);
	localparam int Q_CNT_W   = $clog2(Q_DEPTH + 1);

	localparam int ADDR_W    = 5;
	localparam int DATA_W    = 64;

	localparam logic [1:0] REG_HDR_PATTERN = 2'd0;
	localparam logic [1:0] REG_HDR_LENGTH  = 2'd1;
	localparam logic [1:0] REG_FRM_LENGTH  = 2'd2;

	localparam logic [3:0] HDR_LEN_RST = 4'd1;
	localparam logic [8:0] FRM_LEN_RST = 9'd110;

	typedef enum logic [1:0] {
		JOB_BYTE,
		JOB_ABORT,
		JOB_HEADER
	} job_kind_t;

	// Effective configuration, already clamped
	typedef struct packed {
		logic [PAT_W-1:0]     pattern;
		logic [HDR_CNT_W-1:0] hdr_len;
		logic [FRM_W-1:0]     frm_len;
	} cfg_t;

	typedef struct packed {
		job_kind_t            kind;
		logic [7:0]           data;
		logic                 last;
		logic [HDR_CNT_W-1:0] count;
		logic [PAT_W-1:0]     hdr;
	} job_t;

endpackage
`default_nettype wire

// ===== hdl/sfhh_in_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sfhh_in_if: input request channel
// Carries one received byte or a timeout command per request.
// ----------------------------------------------------------------------------
interface sfhh_in_if;
	logic       valid;
	logic       ready;
	logic       command;
	logic [7:0] data_byte;

	modport source (output valid, output command, output data_byte, input ready);
	modport sink   (input valid, input command, input data_byte, output ready);
endinterface
`default_nettype wire

// ===== hdl/sfhh_out_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sfhh_out_if: output request channel
// Carries one frame byte with its frame marks, or an abort marker.
// ----------------------------------------------------------------------------
interface sfhh_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] frame_byte;
	logic       first_of_frame;
	logic       last_of_frame;
	logic       frame_abort;

	modport source (output valid, output frame_byte, output first_of_frame,
		output last_of_frame, output frame_abort, input ready);
	modport sink   (input valid, input frame_byte, input first_of_frame,
		input last_of_frame, input frame_abort, output ready);
endinterface
`default_nettype wire

// ===== hdl/sfhh_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sfhh_front: hunt and classify
// Takes one request per cycle unless the queue is full, slides the header
// window, tracks the open frame, pushes one job per request that has output.
// ----------------------------------------------------------------------------
module sfhh_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	sfhh_in_if.sink            byte_in,
	input  wire sfhh_pkg::cfg_t cfg,
	input  wire logic          full,
	output logic               push,
	output sfhh_pkg::job_t     push_job
);

	logic [7:0]                     win_q [sfhh_pkg::HDR_MAX];
	logic [sfhh_pkg::HDR_CNT_W-1:0] fill_q;
	logic                           capt_q;
	logic [sfhh_pkg::FRM_W-1:0]     pos_q;

	logic [7:0]                     win_d [sfhh_pkg::HDR_MAX];
	logic [sfhh_pkg::HDR_CNT_W-1:0] fill_d;
	logic                           capt_d;
	logic [sfhh_pkg::FRM_W-1:0]     pos_d;

	logic [7:0]                     shifted [sfhh_pkg::HDR_MAX];
	logic [sfhh_pkg::HDR_CNT_W-1:0] sel [sfhh_pkg::HDR_MAX];
	logic [sfhh_pkg::HDR_MAX-1:0]   byte_ok;
	logic [sfhh_pkg::HDR_CNT_W-1:0] fill_inc;
	logic [sfhh_pkg::FRM_W-1:0]     pos_inc;
	logic                           match;
	logic                           pos_last;
	logic                           accept;

	assign byte_in.ready = !full;
	assign accept        = byte_in.valid && !full;

	// newest byte goes to the top slot
	always_comb begin
		for (int k = 0; k < sfhh_pkg::HDR_MAX - 1; k++) begin
			shifted[k] = win_q[k+1];
		end
		shifted[sfhh_pkg::HDR_MAX-1] = byte_in.data_byte;
	end

	// header byte i sits at slot HDR_MAX - hdr_len + i
	always_comb begin
		for (int i = 0; i < sfhh_pkg::HDR_MAX; i++) begin
			sel[i] = sfhh_pkg::HDR_CNT_W'(sfhh_pkg::HDR_MAX) - cfg.hdr_len
				+ sfhh_pkg::HDR_CNT_W'(i);
			byte_ok[i] = (sfhh_pkg::HDR_CNT_W'(i) >= cfg.hdr_len)
				|| (shifted[sel[i][sfhh_pkg::WIN_IDX_W-1:0]] == cfg.pattern[8*i +: 8]);
		end
	end

	assign fill_inc = (fill_q == sfhh_pkg::HDR_CNT_W'(sfhh_pkg::HDR_MAX)) ? fill_q
		: fill_q + 1'b1;
	assign match    = (fill_inc >= cfg.hdr_len) && (&byte_ok);
	assign pos_inc  = pos_q + 1'b1;
	assign pos_last = pos_inc >= cfg.frm_len;

	always_comb begin
		win_d    = win_q;
		fill_d   = fill_q;
		capt_d   = capt_q;
		pos_d    = pos_q;
		push     = 1'b0;
		push_job = '{kind: sfhh_pkg::JOB_BYTE, data: byte_in.data_byte, last: 1'b0,
			count: cfg.hdr_len, hdr: cfg.pattern};
		if (accept) begin
			if (byte_in.command) begin
				// timeout: drop everything, mark an open frame as aborted
				push          = capt_q;
				push_job.kind = sfhh_pkg::JOB_ABORT;
				for (int k = 0; k < sfhh_pkg::HDR_MAX; k++) begin
					win_d[k] = '0;
				end
				fill_d = '0;
				capt_d = 1'b0;
				pos_d  = '0;
			end else if (capt_q) begin
				push          = 1'b1;
				push_job.last = pos_last;
				capt_d        = !pos_last;
				pos_d         = pos_last ? '0 : pos_inc;
			end else begin
				win_d  = shifted;
				fill_d = fill_inc;
				if (match) begin
					push          = 1'b1;
					push_job.kind = sfhh_pkg::JOB_HEADER;
					push_job.last = cfg.frm_len == sfhh_pkg::FRM_W'(cfg.hdr_len);
					for (int k = 0; k < sfhh_pkg::HDR_MAX; k++) begin
						win_d[k] = '0;
					end
					fill_d = '0;
					capt_d = cfg.frm_len > sfhh_pkg::FRM_W'(cfg.hdr_len);
					pos_d  = capt_d ? sfhh_pkg::FRM_W'(cfg.hdr_len) : '0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < sfhh_pkg::HDR_MAX; k++) begin
				win_q[k] <= '0;
			end
			fill_q <= '0;
			capt_q <= 1'b0;
			pos_q  <= '0;
		end else begin
			win_q  <= win_d;
			fill_q <= fill_d;
			capt_q <= capt_d;
			pos_q  <= pos_d;
		end
	end

endmodule
`default_nettype wire

// ===== hdl/sfhh_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sfhh_queue: job queue
// Small first-in first-out buffer between the front and back ends.
// ----------------------------------------------------------------------------
module sfhh_queue (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  wire sfhh_pkg::job_t push_job,
	input  wire logic           pop,
	output logic                full,
	output logic                empty,
	output sfhh_pkg::job_t      head
);

	sfhh_pkg::job_t               mem_q [sfhh_pkg::Q_DEPTH];
	logic [sfhh_pkg::Q_PTR_W-1:0] wr_ptr_q;
	logic [sfhh_pkg::Q_PTR_W-1:0] rd_ptr_q;
	logic [sfhh_pkg::Q_CNT_W-1:0] cnt_q;
	logic                         do_push;
	logic                         do_pop;

	assign full    = cnt_q == sfhh_pkg::Q_CNT_W'(sfhh_pkg::Q_DEPTH);
	assign empty   = cnt_q == '0;
	assign head    = mem_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

// ===== hdl/sfhh_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sfhh_back: result sequencer
// Unrolls each job into output requests, one per cycle while the output
// side takes them, through a registered output stage.
// ----------------------------------------------------------------------------
module sfhh_back (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           empty,
	input  wire sfhh_pkg::job_t head,
	output logic                pop,
	sfhh_out_if.source          frame_out
);

	logic [sfhh_pkg::WIN_IDX_W-1:0] idx_q;
	logic                           out_valid_q;
	logic [7:0]                     out_byte_q;
	logic                           out_first_q;
	logic                           out_last_q;
	logic                           out_abort_q;

	logic                           issue;
	logic                           hdr_end;
	logic [7:0]                     nxt_byte;
	logic                           nxt_first;
	logic                           nxt_last;
	logic                           nxt_abort;

	assign issue   = !empty && (!out_valid_q || frame_out.ready);
	assign hdr_end = (sfhh_pkg::HDR_CNT_W'(idx_q) + 1'b1) == head.count;

	always_comb begin
		nxt_byte  = head.data;
		nxt_first = 1'b0;
		nxt_last  = head.last;
		nxt_abort = 1'b0;
		pop       = 1'b0;
		case (head.kind)
			sfhh_pkg::JOB_BYTE: begin
				pop = issue;
			end
			sfhh_pkg::JOB_ABORT: begin
				nxt_byte  = '0;
				nxt_last  = 1'b0;
				nxt_abort = 1'b1;
				pop       = issue;
			end
			sfhh_pkg::JOB_HEADER: begin
				nxt_byte  = head.hdr[{idx_q, 3'b000} +: 8];
				nxt_first = idx_q == '0;
				nxt_last  = head.last && hdr_end;
				pop       = issue && hdr_end;
			end
			default: begin
				pop = issue;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (issue) begin
				out_valid_q <= 1'b1;
			end else if (frame_out.ready) begin
				out_valid_q <= 1'b0;
			end
			// step through header bytes, rewind when the job leaves
			if (pop) begin
				idx_q <= '0;
			end else if (issue) begin
				idx_q <= idx_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			out_byte_q  <= nxt_byte;
			out_first_q <= nxt_first;
			out_last_q  <= nxt_last;
			out_abort_q <= nxt_abort;
		end
	end

	assign frame_out.valid          = out_valid_q;
	assign frame_out.frame_byte     = out_byte_q;
	assign frame_out.first_of_frame = out_first_q;
	assign frame_out.last_of_frame  = out_last_q;
	assign frame_out.frame_abort    = out_abort_q;

endmodule
`default_nettype wire

// ===== hdl/serial_frame_header_hunter.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// serial_frame_header_hunter: sliding-header frame synchronizer
// Hunts a serial byte stream for fixed-length frames that open with a
// programmed header, and forwards them cut-through.
// ----------------------------------------------------------------------------
// The block takes one input request per cycle as long as its four-entry job
// queue has room; a received byte or timeout is classified in the cycle it is
// accepted. Output leaves through a registered stage at one request per cycle
// while the output side takes them: a byte inside a frame or an abort marker
// is one output request, a header match releases header_length bytes (1 to 8)
// as that many requests. Sustained rate is therefore one output byte per cycle
// while ready is held, and the input stalls only while the job queue is full,
// which happens while a header burst drains or while the output side holds off
// ready. Configuration is written over the APB port at byte addresses 0, 8 and
// 16 and should change only while the block is idle.
// ----------------------------------------------------------------------------
module serial_frame_header_hunter (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	sfhh_in_if.sink                          byte_in,
	sfhh_out_if.source                       frame_out,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [sfhh_pkg::ADDR_W-1:0] paddr,
	input  wire logic [sfhh_pkg::DATA_W-1:0] pwdata,
	output logic      [sfhh_pkg::DATA_W-1:0] prdata,
	output logic                             pready
);

	logic [sfhh_pkg::PAT_W-1:0]     hdr_pattern_q;
	logic [3:0]                     hdr_length_q;
	logic [8:0]                     frm_length_q;

	logic [1:0]                     reg_sel;
	logic                           wr_en;
	logic [sfhh_pkg::HDR_CNT_W-1:0] hdr_eff;
	logic [sfhh_pkg::FRM_W-1:0]     frm_sat;
	sfhh_pkg::cfg_t                 cfg;

	sfhh_pkg::job_t                 push_job;
	sfhh_pkg::job_t                 head;
	logic                           push;
	logic                           pop;
	logic                           full;
	logic                           empty;

	assign pready  = 1'b1;
	assign reg_sel = paddr[sfhh_pkg::ADDR_W-1:3];
	assign wr_en   = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr_pattern_q <= '0;
			hdr_length_q  <= sfhh_pkg::HDR_LEN_RST;
			frm_length_q  <= sfhh_pkg::FRM_LEN_RST;
		end else if (wr_en) begin
			case (reg_sel)
				sfhh_pkg::REG_HDR_PATTERN: hdr_pattern_q <= pwdata[sfhh_pkg::PAT_W-1:0];
				sfhh_pkg::REG_HDR_LENGTH:  hdr_length_q  <= pwdata[3:0];
				sfhh_pkg::REG_FRM_LENGTH:  frm_length_q  <= pwdata[8:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (reg_sel)
			sfhh_pkg::REG_HDR_PATTERN: prdata = sfhh_pkg::DATA_W'(hdr_pattern_q);
			sfhh_pkg::REG_HDR_LENGTH:  prdata = sfhh_pkg::DATA_W'(hdr_length_q);
			sfhh_pkg::REG_FRM_LENGTH:  prdata = sfhh_pkg::DATA_W'(frm_length_q);
			default:                   prdata = '0;
		endcase
	end

	// clamp header to 1..HDR_MAX, frame to header..FRM_MAX
	always_comb begin
		if (hdr_length_q == '0) begin
			hdr_eff = sfhh_pkg::HDR_CNT_W'(1);
		end else if (hdr_length_q > 4'(sfhh_pkg::HDR_MAX)) begin
			hdr_eff = sfhh_pkg::HDR_CNT_W'(sfhh_pkg::HDR_MAX);
		end else begin
			hdr_eff = sfhh_pkg::HDR_CNT_W'(hdr_length_q);
		end
		if (frm_length_q > 9'(sfhh_pkg::FRM_MAX)) begin
			frm_sat = sfhh_pkg::FRM_W'(sfhh_pkg::FRM_MAX);
		end else begin
			frm_sat = sfhh_pkg::FRM_W'(frm_length_q);
		end
		cfg.pattern = hdr_pattern_q;
		cfg.hdr_len = hdr_eff;
		cfg.frm_len = (frm_sat < sfhh_pkg::FRM_W'(hdr_eff)) ? sfhh_pkg::FRM_W'(hdr_eff)
			: frm_sat;
	end

	sfhh_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.byte_in  (byte_in),
		.cfg      (cfg),
		.full     (full),
		.push     (push),
		.push_job (push_job)
	);

	sfhh_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.full     (full),
		.empty    (empty),
		.head     (head)
	);

	sfhh_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.empty     (empty),
		.head      (head),
		.pop       (pop),
		.frame_out (frame_out)
	);

endmodule
`default_nettype wire

// ===== tb/sv/tb.sv =====
// ----------------------------------------------------------------------------
// tb: self-checking bench for serial_frame_header_hunter
// Feeds received bytes and timeouts through the input channel and keeps a
// shadow of the window, frame state and registers. Every byte that leaves is
// checked in order against the shadow. Register settings change over APB
// between phases, and both channels are throttled at random.
// ----------------------------------------------------------------------------
module tb;

	localparam bit CMD_BYTE    = 1'b0;
	localparam bit CMD_TIMEOUT = 1'b1;

	typedef struct packed {
		logic [7:0] frame_byte;
		logic       first_of_frame;
		logic       last_of_frame;
		logic       frame_abort;
	} frame_res_t;

	class frame_sync_shadow;
		logic [63:0] pattern;
		logic [3:0]  hdr_len_reg;
		logic [8:0]  frm_len_reg;
		logic [7:0]  window [sfhh_pkg::HDR_MAX];
		int unsigned fill;
		bit          in_frame;
		int unsigned frame_pos;
		frame_res_t  frames_due [$];
		int unsigned mismatches;
		int unsigned opened;
		int unsigned closed;
		int unsigned aborts;

		function new();
			pattern     = '0;
			hdr_len_reg = 4'd1;
			frm_len_reg = 9'd110;
			in_frame    = 1'b0;
			frame_pos   = 0;
			mismatches  = 0;
			opened      = 0;
			closed      = 0;
			aborts      = 0;
			clear_window();
		endfunction

		function void clear_window();
			foreach (window[k]) window[k] = 8'h00;
			fill = 0;
		endfunction

		function int unsigned header_span();
			if (hdr_len_reg == 0) return 1;
			if (hdr_len_reg > sfhh_pkg::HDR_MAX) return sfhh_pkg::HDR_MAX;
			return hdr_len_reg;
		endfunction

		function int unsigned frame_span();
			int unsigned f;
			f = (frm_len_reg > sfhh_pkg::FRM_MAX) ? sfhh_pkg::FRM_MAX : frm_len_reg;
			if (f < header_span()) f = header_span();
			return f;
		endfunction

		function void write_reg(logic [1:0] idx, logic [63:0] value);
			case (idx)
				sfhh_pkg::REG_HDR_PATTERN: pattern = value;
				sfhh_pkg::REG_HDR_LENGTH:  hdr_len_reg = value[3:0];
				sfhh_pkg::REG_FRM_LENGTH:  frm_len_reg = value[8:0];
				default: ;
			endcase
		endfunction

		function void queue_out(logic [7:0] b, bit first, bit last, bit abort_flag);
			frame_res_t r;
			r.frame_byte     = b;
			r.first_of_frame = first;
			r.last_of_frame  = last;
			r.frame_abort    = abort_flag;
			frames_due.push_back(r);
		endfunction

		function int unsigned pending();
			return frames_due.size();
		endfunction

		// advance the shadow by one accepted input request
		function void take_request(bit cmd, logic [7:0] b);
			int unsigned h;
			int unsigned f;
			int unsigned k;
			h = header_span();
			f = frame_span();
			if (cmd == CMD_TIMEOUT) begin
				if (in_frame) queue_out(8'h00, 1'b0, 1'b0, 1'b1);
				in_frame  = 1'b0;
				frame_pos = 0;
				clear_window();
				return;
			end
			if (in_frame) begin
				frame_pos++;
				queue_out(b, 1'b0, frame_pos >= f, 1'b0);
				if (frame_pos >= f) begin
					in_frame  = 1'b0;
					frame_pos = 0;
				end
				return;
			end
			for (k = 0; k < sfhh_pkg::HDR_MAX - 1; k++) window[k] = window[k + 1];
			window[sfhh_pkg::HDR_MAX - 1] = b;
			if (fill < sfhh_pkg::HDR_MAX) fill++;
			if (fill < h) return;
			for (k = 0; k < h; k++) begin
				if (window[sfhh_pkg::HDR_MAX - h + k] != pattern[8 * k +: 8]) return;
			end
			for (k = 0; k < h; k++) begin
				queue_out(window[sfhh_pkg::HDR_MAX - h + k], k == 0,
					(k + 1 == h) && (f == h), 1'b0);
			end
			clear_window();
			if (f > h) begin
				in_frame  = 1'b1;
				frame_pos = h;
			end
		endfunction

		function void compare_field(string name, logic [7:0] want, logic [7:0] got);
			if (got !== want) begin
				$display("%0t: %s expected %02h, got %02h", $time, name, want, got);
				mismatches++;
			end
		endfunction

		function void match_output(frame_res_t got);
			frame_res_t want;
			if (got.first_of_frame === 1'b1) opened++;
			if (got.last_of_frame === 1'b1) closed++;
			if (got.frame_abort === 1'b1) aborts++;
			if (frames_due.size() == 0) begin
				$display("%0t: unexpected output, expected none, got byte %02h first %b last %b abort %b",
					$time, got.frame_byte, got.first_of_frame, got.last_of_frame, got.frame_abort);
				mismatches++;
				return;
			end
			want = frames_due.pop_front();
			compare_field("frame_byte", want.frame_byte, got.frame_byte);
			compare_field("first_of_frame", 8'(want.first_of_frame), 8'(got.first_of_frame));
			compare_field("last_of_frame", 8'(want.last_of_frame), 8'(got.last_of_frame));
			compare_field("frame_abort", 8'(want.frame_abort), 8'(got.frame_abort));
		endfunction
	endclass

	logic                        clk;
	logic                        arst_n;
	logic                        psel;
	logic                        penable;
	logic                        pwrite;
	logic [sfhh_pkg::ADDR_W-1:0] paddr;
	logic [sfhh_pkg::DATA_W-1:0] pwdata;
	logic [sfhh_pkg::DATA_W-1:0] prdata;
	logic                        pready;

	sfhh_in_if  byte_in ();
	sfhh_out_if frame_out ();

	serial_frame_header_hunter dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.byte_in   (byte_in),
		.frame_out (frame_out),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	frame_sync_shadow shadow = new();
	frame_res_t       seen_out;
	int unsigned      send_idle_pct;
	int unsigned      recv_idle_pct;
	int unsigned      requests_sent;
	int unsigned      timeouts_sent;
	int unsigned      configs_used;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	initial begin
		#3_000_000;
		$display("simulation failed");
		$finish;
	end

	always @(negedge clk) begin
		frame_out.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
	end

	always @(posedge clk) begin
		if (arst_n && frame_out.valid && frame_out.ready) begin
			seen_out.frame_byte     = frame_out.frame_byte;
			seen_out.first_of_frame = frame_out.first_of_frame;
			seen_out.last_of_frame  = frame_out.last_of_frame;
			seen_out.frame_abort    = frame_out.frame_abort;
			shadow.match_output(seen_out);
		end
	end

	task automatic send_request(input bit cmd, input logic [7:0] b);
		@(negedge clk);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			byte_in.valid <= 1'b0;
			@(negedge clk);
		end
		byte_in.valid     <= 1'b1;
		byte_in.command   <= cmd;
		byte_in.data_byte <= b;
		@(posedge clk);
		while (!byte_in.ready) @(posedge clk);
		shadow.take_request(cmd, b);
		requests_sent++;
		if (cmd == CMD_TIMEOUT) timeouts_sent++;
	endtask

	task automatic hold_input();
		@(negedge clk);
		byte_in.valid <= 1'b0;
	endtask

	task automatic pause_until_drained();
		hold_input();
		while (shadow.pending() != 0) @(posedge clk);
	endtask

	// let trailing requests that produce nothing clear the job queue too
	task automatic drain();
		pause_until_drained();
		repeat (16) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [63:0] value);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 3'b000};
		pwdata  <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		shadow.write_reg(idx, value);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic set_config(input logic [63:0] pat, input logic [3:0] hl, input logic [8:0] fl);
		drain();
		write_reg(sfhh_pkg::REG_HDR_PATTERN, pat);
		write_reg(sfhh_pkg::REG_HDR_LENGTH, 64'(hl));
		write_reg(sfhh_pkg::REG_FRM_LENGTH, 64'(fl));
		configs_used++;
	endtask

	task automatic random_config();
		logic [63:0] pat;
		logic [3:0]  hl;
		logic [8:0]  fl;
		int unsigned h;
		pat = {$urandom, $urandom};
		if ($urandom_range(0, 9) == 0) pat = '1;
		if ($urandom_range(0, 4) == 0) hl = 4'($urandom_range(0, 15));
		else hl = 4'($urandom_range(1, 4));
		h = (hl == 0) ? 1 : ((hl > sfhh_pkg::HDR_MAX) ? sfhh_pkg::HDR_MAX : hl);
		case ($urandom_range(0, 5))
			0: fl = 9'($urandom_range(0, h));
			1: fl = 9'($urandom_range(0, 511));
			default: fl = 9'(h + $urandom_range(0, 5));
		endcase
		set_config(pat, hl, fl);
	endtask

	// mostly clean headers with a short body, some broken headers, noise and timeouts
	task automatic hunt_burst();
		int unsigned h;
		int unsigned f;
		int unsigned n;
		int unsigned k;
		int unsigned pick;
		h    = shadow.header_span();
		f    = shadow.frame_span();
		pick = $urandom_range(0, 99);
		if (pick < 65) begin
			for (k = 0; k < h; k++) send_request(CMD_BYTE, shadow.pattern[8 * k +: 8]);
			n = (f - h > 10) ? 10 : f - h;
			for (k = 0; k < n; k++) begin
				if ($urandom_range(0, 99) < 4) begin
					send_request(CMD_TIMEOUT, 8'($urandom));
					break;
				end
				send_request(CMD_BYTE, 8'($urandom));
			end
		end else if (pick < 80) begin
			n = $urandom_range(0, h - 1);
			for (k = 0; k < n; k++) send_request(CMD_BYTE, shadow.pattern[8 * k +: 8]);
			send_request(CMD_BYTE, shadow.pattern[8 * n +: 8] ^ 8'($urandom_range(1, 255)));
		end else if (pick < 92) begin
			repeat ($urandom_range(1, 4)) send_request(CMD_BYTE, 8'($urandom));
		end else begin
			send_request(CMD_TIMEOUT, 8'($urandom));
		end
	endtask

	task automatic run_phase(input int unsigned quota);
		int unsigned start;
		bit          paused;
		random_config();
		start  = requests_sent;
		paused = 1'b0;
		while (requests_sent - start < quota) begin
			if (!paused && requests_sent - start >= quota / 2) begin
				pause_until_drained();
				paused = 1'b1;
			end
			hunt_burst();
		end
	endtask

	initial begin
		int mode;
		arst_n              = 1'b0;
		psel                = 1'b0;
		penable             = 1'b0;
		pwrite              = 1'b0;
		paddr               = '0;
		pwdata              = '0;
		byte_in.valid       = 1'b0;
		byte_in.command     = CMD_BYTE;
		byte_in.data_byte   = 8'h00;
		frame_out.ready     = 1'b0;
		send_idle_pct       = 25;
		recv_idle_pct       = 25;
		requests_sent       = 0;
		timeouts_sent       = 0;
		configs_used        = 1;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset settings: one-byte zero header, 110-byte frames
		send_request(CMD_BYTE, 8'h00);
		send_request(CMD_BYTE, 8'hFF);
		send_request(CMD_TIMEOUT, 8'hFF);
		send_request(CMD_TIMEOUT, 8'h00);
		send_request(CMD_BYTE, 8'h01);

		// oversized header length clamps to eight, frame shorter than header
		set_config(64'h8001_FF00_7FFE_55AA, 4'd15, 9'd3);
		send_request(CMD_BYTE, 8'h12);
		send_request(CMD_BYTE, 8'hAA);
		send_request(CMD_BYTE, 8'h55);
		send_request(CMD_BYTE, 8'hFE);
		send_request(CMD_BYTE, 8'h7F);
		send_request(CMD_BYTE, 8'h00);
		send_request(CMD_BYTE, 8'hFF);
		send_request(CMD_BYTE, 8'h01);
		send_request(CMD_BYTE, 8'h80);

		// zero header and frame lengths act as one
		set_config(64'h8001_FF00_7FFE_55AA, 4'd0, 9'd0);
		send_request(CMD_BYTE, 8'hAA);
		send_request(CMD_BYTE, 8'h55);

		// shorten the frame while it is open
		set_config(64'h8001_FF00_7FFE_55AA, 4'd2, 9'd511);
		send_request(CMD_BYTE, 8'hAA);
		send_request(CMD_BYTE, 8'h55);
		send_request(CMD_BYTE, 8'h0F);
		drain();
		write_reg(sfhh_pkg::REG_FRM_LENGTH, 64'd4);
		send_request(CMD_BYTE, 8'hF0);
		drain();
		write_reg(sfhh_pkg::REG_FRM_LENGTH, 64'd1);
		send_request(CMD_BYTE, 8'hAA);
		send_request(CMD_BYTE, 8'h55);

		// long frame under a saturated length, dropped part way by a timeout
		set_config('1, 4'd1, 9'd511);
		send_request(CMD_BYTE, 8'hFF);
		repeat (60) send_request(CMD_BYTE, 8'($urandom));
		send_request(CMD_TIMEOUT, 8'h00);

		for (mode = 0; mode < 3; mode++) begin
			case (mode)
				0: begin
					send_idle_pct = 36;
					recv_idle_pct = 86;
				end
				1: begin
					send_idle_pct = 86;
					recv_idle_pct = 36;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			repeat (2) run_phase(18);
		end

		drain();
		$display("sent %0d requests (%0d timeouts) over %0d register settings",
			requests_sent, timeouts_sent, configs_used);
		$display("saw %0d frame starts, %0d frame ends, %0d aborts, %0d mismatches",
			shadow.opened, shadow.closed, shadow.aborts, shadow.mismatches);
		if (shadow.mismatches == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end
endmodule
